// File: hdl/rsa_pkg.sv
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and sizes for the request slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package rsa_pkg;

   // Pool size and the widths that follow from it
   localparam int POOL_SLOTS = 2048;
   localparam int INDEX_W    = $clog2(POOL_SLOTS);
   localparam int LINK_W     = $clog2(POOL_SLOTS + 1);
   localparam int SLOT_W     = 11;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_ALLOC    = 2'd0,
      KIND_FREE     = 2'd1,
      KIND_COMPLETE = 2'd2,
      KIND_QUERY    = 2'd3
   } kind_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [LINK_W-1:0]  link_type;
   typedef logic [SLOT_W-1:0]  slot_type;

endpackage : rsa_pkg

`default_nettype wire

// File: hdl/rsa_if.sv
// ----------------------------------------------------------------------------
// rsa_if
// Valid/ready channels of the request slot allocator: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsa_req_if;
   logic               valid;
   logic               ready;
   rsa_pkg::kind_type  kind;
   rsa_pkg::slot_type  slot;

   modport source (output valid, output kind, output slot, input ready);
   modport sink   (input valid, input kind, input slot, output ready);
endinterface : rsa_req_if

interface rsa_rsp_if;
   logic               valid;
   logic               ready;
   rsa_pkg::slot_type  granted_slot;
   logic               status;
   logic               slot_done;

   modport source (output valid, output granted_slot, output status,
                   output slot_done, input ready);
   modport sink   (input valid, input granted_slot, input status,
                   input slot_done, output ready);
endinterface : rsa_rsp_if

`default_nettype wire

// File: hdl/rsa_ram.sv
// ----------------------------------------------------------------------------
// rsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, then register the read data on a read strobe
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : rsa_ram

`default_nettype wire

// File: hdl/request_slot_allocator.sv
// ----------------------------------------------------------------------------
// request_slot_allocator
// LIFO free list of request slots with per-slot done marks.
// ----------------------------------------------------------------------------
// On accept the link memory is read at the list head and the done memory at
// the requested slot. In the update state (ST_EXEC) the read data from the
// synchronous RAM is used; once the output register is free or being taken,
// the memories and head register are updated and the response is loaded into
// the output register. A response that is not taken holds the next request in
// its update cycle. After reset the block runs an initialization sweep over
// all POOL_SLOTS (2048) entries that chains the links and clears the done
// marks; no request is accepted during the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module request_slot_allocator (
   input wire logic  clock,
   input wire logic  reset,
   rsa_req_if.sink   req_chan,
   rsa_rsp_if.source rsp_chan
);

   localparam rsa_pkg::index_type INIT_LAST = rsa_pkg::INDEX_W'(rsa_pkg::POOL_SLOTS - 1);

   // Control state
   rsa_pkg::state_type state_ff, state_in;
   rsa_pkg::index_type init_idx_ff, init_idx_in;
   rsa_pkg::link_type  list_head_ff, list_head_in;

   // Captured request
   rsa_pkg::kind_type  kind_ff;
   rsa_pkg::slot_type  slot_ff;
   logic               in_pool_ff;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsa_pkg::slot_type  rsp_granted_ff, rsp_granted_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_done_ff, rsp_done_in;

   // Memory ports
   logic               link_wr_en, link_rd_en;
   rsa_pkg::index_type link_wr_addr, link_rd_addr;
   rsa_pkg::link_type  link_wr_data, link_rd_data;
   logic               done_wr_en, done_rd_en;
   rsa_pkg::index_type done_wr_addr, done_rd_addr;
   logic               done_wr_data, done_rd_data;

   logic               accept;
   logic               load_out;
   logic               head_empty;
   rsa_pkg::index_type head_idx;
   rsa_pkg::index_type slot_idx;

   rsa_ram #(.WIDTH(rsa_pkg::LINK_W), .DEPTH(rsa_pkg::POOL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   rsa_ram #(.WIDTH(1), .DEPTH(rsa_pkg::POOL_SLOTS)) u_done_ram (
      .clock   (clock),
      .wr_en   (done_wr_en),
      .wr_addr (done_wr_addr),
      .wr_data (done_wr_data),
      .rd_en   (done_rd_en),
      .rd_addr (done_rd_addr),
      .rd_data (done_rd_data)
   );

   // Handshake
   assign req_chan.ready = (state_ff == rsa_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign load_out       = (state_ff == rsa_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   assign head_empty = 32'(list_head_ff) >= rsa_pkg::POOL_SLOTS;
   assign head_idx   = rsa_pkg::INDEX_W'(list_head_ff);
   assign slot_idx   = rsa_pkg::INDEX_W'(slot_ff);

   // Issue reads on accept: link at the head, done mark at the slot
   assign link_rd_en   = accept;
   assign link_rd_addr = head_idx;
   assign done_rd_en   = accept;
   assign done_rd_addr = rsa_pkg::INDEX_W'(req_chan.slot);

   // Next state, memory writes and response
   always_comb begin
      state_in       = state_ff;
      init_idx_in    = init_idx_ff;
      list_head_in   = list_head_ff;
      link_wr_en     = 1'b0;
      link_wr_addr   = slot_idx;
      link_wr_data   = list_head_ff;
      done_wr_en     = 1'b0;
      done_wr_addr   = slot_idx;
      done_wr_data   = 1'b0;
      rsp_granted_in = '0;
      rsp_status_in  = 1'b0;
      rsp_done_in    = 1'b0;

      unique case (state_ff)
         rsa_pkg::ST_INIT: begin
            // Chain entry i to i+1 and clear its done mark
            link_wr_en   = 1'b1;
            link_wr_addr = init_idx_ff;
            link_wr_data = rsa_pkg::LINK_W'(init_idx_ff) + rsa_pkg::LINK_W'(1);
            done_wr_en   = 1'b1;
            done_wr_addr = init_idx_ff;
            done_wr_data = 1'b0;
            init_idx_in  = init_idx_ff + rsa_pkg::INDEX_W'(1);
            if (init_idx_ff == INIT_LAST) begin
               state_in = rsa_pkg::ST_IDLE;
            end
         end
         rsa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rsa_pkg::ST_EXEC;
            end
         end
         rsa_pkg::ST_EXEC: begin
            case (kind_ff)
               rsa_pkg::KIND_ALLOC: begin
                  // Pop the head and clear its done mark
                  if (head_empty) begin
                     rsp_status_in = 1'b1;
                  end else begin
                     list_head_in   = link_rd_data;
                     done_wr_en     = load_out;
                     done_wr_addr   = head_idx;
                     done_wr_data   = 1'b0;
                     rsp_granted_in = rsa_pkg::SLOT_W'(list_head_ff);
                  end
               end
               rsa_pkg::KIND_FREE: begin
                  // Push the slot onto the head
                  if (in_pool_ff) begin
                     link_wr_en   = load_out;
                     link_wr_addr = slot_idx;
                     link_wr_data = list_head_ff;
                     list_head_in = rsa_pkg::LINK_W'(slot_ff);
                  end
               end
               rsa_pkg::KIND_COMPLETE: begin
                  if (in_pool_ff) begin
                     done_wr_en   = load_out;
                     done_wr_addr = slot_idx;
                     done_wr_data = 1'b1;
                  end
               end
               default: begin
                  rsp_done_in = in_pool_ff && done_rd_data;
               end
            endcase
            if (load_out) begin
               state_in = rsa_pkg::ST_IDLE;
            end else begin
               list_head_in = list_head_ff;
            end
         end
         default: begin
            state_in = rsa_pkg::ST_INIT;
         end
      endcase
   end

   // Output register: load on update, drop on transfer
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::ST_INIT;
         init_idx_ff  <= '0;
         list_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         list_head_ff <= list_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture request on accept, response on load
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_chan.kind;
         slot_ff    <= req_chan.slot;
         in_pool_ff <= 32'(req_chan.slot) < rsa_pkg::POOL_SLOTS;
      end
      if (load_out) begin
         rsp_granted_ff <= rsp_granted_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_done_ff    <= rsp_done_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.granted_slot = rsp_granted_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.slot_done    = rsp_done_ff;

   // Head never leaves the range of slot indexes plus the empty mark
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      32'(list_head_ff) <= rsa_pkg::POOL_SLOTS)
      else $error("list head out of range");

   // An exhausted response carries no slot and no done mark
   a_exhausted_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_granted_ff == '0) && !rsp_done_ff)
      else $error("exhausted response carries payload");

   // An accepted request moves to the update cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == rsa_pkg::ST_EXEC))
      else $error("accepted request not executed");

   // Sweep hands over to idle after the last entry
   a_init_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rsa_pkg::ST_INIT && init_idx_ff == INIT_LAST)
      |=> (state_ff == rsa_pkg::ST_IDLE))
      else $error("initialization sweep did not finish");

   // No memory write outside the sweep unless a response is loaded
   a_write_on_load: assert property (@(posedge clock) disable iff (reset)
      ((link_wr_en || done_wr_en) && state_ff != rsa_pkg::ST_INIT) |-> load_out)
      else $error("memory written without a response");

endmodule : request_slot_allocator

`default_nettype wire
